FILE: rtl/c8ie_pkg.sv
// Shared types and constants for the CHIP-8 instruction executor.
package c8ie_pkg;

   localparam int unsigned PC_W        = 12;
   localparam int unsigned INSTR_W     = 16;
   localparam int unsigned VREG_W      = 8;
   localparam int unsigned VIDX_W      = 4;
   localparam int unsigned NUM_V       = 16;
   localparam int unsigned REQ_DATA_W  = 16;

   localparam int unsigned STACK_DEPTH_DEFAULT = 16;

   localparam logic [PC_W-1:0]    PROGRAM_START_RESET = 12'h200;
   localparam logic [PC_W-1:0]    PC_STEP             = 12'h002;
   localparam logic [VIDX_W-1:0]  VF_INDEX            = 4'hF;
   localparam logic [INSTR_W-1:0] INSTR_CLS           = 16'h00E0;
   localparam logic [INSTR_W-1:0] INSTR_RET           = 16'h00EE;

   // Operation group, selected by the top nibble of the instruction.
   typedef enum logic [3:0] {
      OP_SYS     = 4'h0,
      OP_JP      = 4'h1,
      OP_CALL    = 4'h2,
      OP_SE_IMM  = 4'h3,
      OP_SNE_IMM = 4'h4,
      OP_SE_REG  = 4'h5,
      OP_LD_IMM  = 4'h6,
      OP_ADD_IMM = 4'h7,
      OP_ALU     = 4'h8,
      OP_SNE_REG = 4'h9
   } op_type;

   // ALU function of the 8XYn group, selected by the low nibble.
   typedef enum logic [3:0] {
      ALU_LD   = 4'h0,
      ALU_OR   = 4'h1,
      ALU_AND  = 4'h2,
      ALU_XOR  = 4'h3,
      ALU_ADD  = 4'h4,
      ALU_SUB  = 4'h5,
      ALU_SHR  = 4'h6,
      ALU_SUBN = 4'h7,
      ALU_SHL  = 4'hE
   } alu_type;

   // Result word fields, last member in the lowest bits.
   typedef struct packed {
      logic              illegal_op;
      logic [VREG_W-1:0] flag_value;
      logic [VREG_W-1:0] reg_write_value;
      logic [VIDX_W-1:0] reg_write_index;
      logic              reg_write_valid;
      logic              clear_display;
      logic [PC_W-1:0]   next_pc;
   } rsp_fields_type;

   localparam int unsigned RSP_FIELDS_W = $bits(rsp_fields_type);
   localparam int unsigned RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

endpackage

FILE: rtl/chip8_instruction_executor_unit.sv
// CHIP-8 instruction executor: decode, register file, ALU, PC and return stack.
//
//   Channel  Direction  Payload
//   req_*    in         tdata[15:0] = instruction
//   rsp_*    out        tdata[39:0] = next_pc, clear_display, reg_write_valid,
//                       reg_write_index, reg_write_value, flag_value, illegal_op
//   csr_*    in         csr_wr_data[11:0] = program_start (also loads the PC)
//
// A word accepted on req is latched together with its two V-register reads and
// is executed once the rsp output register can take it; the result lands there.
// One word is taken every cycle while rsp_tready keeps the output draining; the
// result passes the execute and rsp output registers, then rsp_tvalid rises.
// The one-cycle rate is set by the execute step, which reads the PC, the stack
// pointer and VF as left by the word just before it.
// Reset clears the PC to 0x200, the stack pointer, VF, the register valid bits
// and the return stack.
// When rsp_tready is low the result holds, and req_tready drops only once the
// word in the execute register also has nowhere to go.
module chip8_instruction_executor_unit #(
   parameter int unsigned STACK_DEPTH = c8ie_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0 up: instruction[15:0].
   input  logic [c8ie_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Fields from bit 0 up: next_pc[11:0], clear_display, reg_write_valid,
   // reg_write_index[3:0], reg_write_value[7:0], flag_value[7:0], illegal_op,
   // then zero fill.
   output logic [c8ie_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [c8ie_pkg::PC_W-1:0]         csr_wr_data
);
   import c8ie_pkg::*;

   localparam int unsigned SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);
   localparam logic [SP_W-1:0] SP_ONE  = SP_W'(1);

   // Handshake and pipeline control.
   logic accept;
   logic advance;
   logic ex_fire;

   // Execute register: the instruction and its operand reads.
   logic                 ex_valid_ff, ex_valid_in;
   logic [INSTR_W-1:0]   ex_instr_ff;
   logic [VREG_W-1:0]    vx_mem_ff, vy_mem_ff;
   logic                 vx_vld_ff, vy_vld_ff;
   logic                 vx_byp_ff, vy_byp_ff;
   logic [VREG_W-1:0]    byp_data_ff;

   // Architectural state. V0..VE live in the register memory, VF in a flop.
   logic [VREG_W-1:0]    v_mem [NUM_V];
   logic [NUM_V-1:0]     v_valid_ff;
   logic [VREG_W-1:0]    vf_ff;
   logic [PC_W-1:0]      pc_ff;
   logic [SP_W-1:0]      sp_ff;
   logic [PC_W-1:0]      ret_stack_ff [STACK_DEPTH];

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_fields_type       rsp_data_ff, rsp_data_in;

   // Decode and execute.
   logic [VIDX_W-1:0]    req_x, req_y;
   logic [VIDX_W-1:0]    ex_x, ex_y;
   logic [3:0]           ex_n;
   logic [VREG_W-1:0]    ex_kk;
   logic [PC_W-1:0]      ex_nnn;
   logic [VREG_W-1:0]    vx, vy;
   logic [VREG_W:0]      add_sum;
   logic [PC_W-1:0]      pc_inc, pc_skip, pc_next;
   logic [SP_W-1:0]      sp_inc, sp_dec, sp_next;
   logic                 push;
   logic                 wr, fwr, cls, illegal, skip;
   logic [VREG_W-1:0]    wval, fval, vf_next;

   // The execute register moves on whenever the output register is free or
   // is being emptied in this cycle.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign ex_fire    = ex_valid_ff && advance;
   assign req_tready = !ex_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}}, rsp_data_ff};

   assign req_x = req_tdata[11:8];
   assign req_y = req_tdata[7:4];

   assign ex_x   = ex_instr_ff[11:8];
   assign ex_y   = ex_instr_ff[7:4];
   assign ex_n   = ex_instr_ff[3:0];
   assign ex_kk  = ex_instr_ff[7:0];
   assign ex_nnn = ex_instr_ff[PC_W-1:0];

   // Operand select. VF is always taken from its own flop. Other registers come
   // from the bypass if the previous word wrote them while this one was being
   // latched, otherwise from the memory, and read as zero until first written.
   always_comb begin
      if (ex_x == VF_INDEX) begin
         vx = vf_ff;
      end else if (vx_byp_ff) begin
         vx = byp_data_ff;
      end else if (vx_vld_ff) begin
         vx = vx_mem_ff;
      end else begin
         vx = '0;
      end
      if (ex_y == VF_INDEX) begin
         vy = vf_ff;
      end else if (vy_byp_ff) begin
         vy = byp_data_ff;
      end else if (vy_vld_ff) begin
         vy = vy_mem_ff;
      end else begin
         vy = '0;
      end
   end

   assign add_sum = {1'b0, vx} + {1'b0, vy};
   assign pc_inc  = pc_ff + PC_STEP;
   assign pc_skip = pc_inc + PC_STEP;
   assign sp_inc  = (sp_ff == SP_LAST) ? '0 : sp_ff + SP_ONE;
   assign sp_dec  = (sp_ff == '0) ? SP_LAST : sp_ff - SP_ONE;

   always_comb begin
      pc_next = pc_inc;
      sp_next = sp_ff;
      push    = 1'b0;
      wr      = 1'b0;
      wval    = '0;
      fwr     = 1'b0;
      fval    = '0;
      cls     = 1'b0;
      illegal = 1'b0;
      skip    = 1'b0;
      case (op_type'(ex_instr_ff[15:12]))
         OP_SYS: begin
            if (ex_instr_ff == INSTR_CLS) begin
               cls = 1'b1;
            end else if (ex_instr_ff == INSTR_RET) begin
               sp_next = sp_dec;
               pc_next = ret_stack_ff[sp_dec];
            end else begin
               illegal = 1'b1;
            end
         end
         OP_JP: begin
            pc_next = ex_nnn;
         end
         OP_CALL: begin
            push    = 1'b1;
            sp_next = sp_inc;
            pc_next = ex_nnn;
         end
         OP_SE_IMM: begin
            skip = (vx == ex_kk);
         end
         OP_SNE_IMM: begin
            skip = (vx != ex_kk);
         end
         OP_SE_REG: begin
            if (ex_n != '0) begin
               illegal = 1'b1;
            end else begin
               skip = (vx == vy);
            end
         end
         OP_LD_IMM: begin
            wr   = 1'b1;
            wval = ex_kk;
         end
         OP_ADD_IMM: begin
            wr   = 1'b1;
            wval = vx + ex_kk;
         end
         OP_ALU: begin
            case (alu_type'(ex_n))
               ALU_LD: begin
                  wr   = 1'b1;
                  wval = vy;
               end
               ALU_OR: begin
                  wr   = 1'b1;
                  wval = vx | vy;
               end
               ALU_AND: begin
                  wr   = 1'b1;
                  wval = vx & vy;
               end
               ALU_XOR: begin
                  wr   = 1'b1;
                  wval = vx ^ vy;
               end
               ALU_ADD: begin
                  fwr  = 1'b1;
                  fval = VREG_W'(add_sum[VREG_W]);
                  wr   = 1'b1;
                  wval = add_sum[VREG_W-1:0];
               end
               ALU_SUB: begin
                  fwr  = 1'b1;
                  fval = VREG_W'(vx > vy);
                  wr   = 1'b1;
                  wval = vx - vy;
               end
               ALU_SHR: begin
                  fwr  = 1'b1;
                  fval = VREG_W'(vx[0]);
                  wr   = 1'b1;
                  wval = vx >> 1;
               end
               ALU_SUBN: begin
                  fwr  = 1'b1;
                  fval = VREG_W'(vy > vx);
                  wr   = 1'b1;
                  wval = vy - vx;
               end
               ALU_SHL: begin
                  fwr  = 1'b1;
                  fval = VREG_W'(vx[VREG_W-1]);
                  wr   = 1'b1;
                  wval = vx << 1;
               end
               default: begin
                  illegal = 1'b1;
               end
            endcase
         end
         OP_SNE_REG: begin
            if (ex_n != '0) begin
               illegal = 1'b1;
            end else begin
               skip = (vx != vy);
            end
         end
         default: begin
            illegal = 1'b1;
         end
      endcase
      if (skip) begin
         pc_next = pc_skip;
      end
   end

   // The flag is written first, so a result aimed at VF itself wins.
   always_comb begin
      if (wr && (ex_x == VF_INDEX)) begin
         vf_next = wval;
      end else if (fwr) begin
         vf_next = fval;
      end else begin
         vf_next = vf_ff;
      end
   end

   always_comb begin
      rsp_data_in.next_pc         = pc_next;
      rsp_data_in.clear_display   = cls;
      rsp_data_in.reg_write_valid = wr;
      rsp_data_in.reg_write_index = wr ? ex_x : '0;
      rsp_data_in.reg_write_value = wr ? wval : '0;
      rsp_data_in.flag_value      = vf_next;
      rsp_data_in.illegal_op      = illegal;
   end

   always_comb begin
      ex_valid_in = ex_valid_ff;
      if (accept) begin
         ex_valid_in = 1'b1;
      end else if (ex_fire) begin
         ex_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (ex_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Register memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (ex_fire && wr) begin
         v_mem[ex_x] <= wval;
      end
      if (accept) begin
         vx_mem_ff <= v_mem[req_x];
         vy_mem_ff <= v_mem[req_y];
      end
   end

   // Operand latch with bypass of a write made in the same cycle.
   always_ff @(posedge clock) begin
      if (accept) begin
         ex_instr_ff <= req_tdata[INSTR_W-1:0];
         vx_vld_ff   <= v_valid_ff[req_x];
         vy_vld_ff   <= v_valid_ff[req_y];
         vx_byp_ff   <= ex_fire && wr && (ex_x == req_x);
         vy_byp_ff   <= ex_fire && wr && (ex_x == req_y);
         byp_data_ff <= wval;
      end
      if (ex_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         v_valid_ff   <= '0;
         vf_ff        <= '0;
         pc_ff        <= PROGRAM_START_RESET;
         sp_ff        <= '0;
         for (int i = 0; i < STACK_DEPTH; i++) begin
            ret_stack_ff[i] <= '0;
         end
      end else begin
         ex_valid_ff  <= ex_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            pc_ff <= csr_wr_data;
         end else if (ex_fire) begin
            pc_ff <= pc_next;
         end
         if (ex_fire) begin
            vf_ff <= vf_next;
            sp_ff <= sp_next;
            if (wr) begin
               v_valid_ff[ex_x] <= 1'b1;
            end
            if (push) begin
               ret_stack_ff[sp_ff] <= pc_inc;
            end
         end
      end
   end

endmodule

FILE: rtl/c8ie_checker.sv
// Port-level checker for the CHIP-8 instruction executor, with its bind.
module c8ie_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [c8ie_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import c8ie_pkg::*;

   rsp_fields_type rsp_fields;

   assign rsp_fields = rsp_fields_type'(rsp_tdata[RSP_FIELDS_W-1:0]);

   // A result word that is not taken stays as it is.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // Reset empties the pipeline and opens the input.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   // An accepted word reaches the output if the output drains while it is in execute.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready |=> rsp_tvalid)
      else $error("accepted word did not produce a result");

   // An unhandled opcode writes nothing and does not clear the display.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_fields.illegal_op |->
         !rsp_fields.reg_write_valid && !rsp_fields.clear_display)
      else $error("illegal opcode had side effects");

   // Without a register write the write index and value read as zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_fields.reg_write_valid |->
         (rsp_fields.reg_write_index == '0) && (rsp_fields.reg_write_value == '0))
      else $error("write fields set without a register write");

endmodule

bind chip8_instruction_executor_unit c8ie_checker u_c8ie_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: dv/tb_chip8_instruction_executor_unit.sv
// Self-checking testbench for the CHIP-8 instruction executor unit.
`timescale 1ns / 1ps

module tb_chip8_instruction_executor_unit;
   import c8ie_pkg::*;

   localparam int unsigned STACK_DEPTH    = STACK_DEPTH_DEFAULT;
   // Cycles with no word moving on either channel before the run is declared hung.
   // The longest honest quiet stretch is the receiver hold-off.
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned HOLD_CYCLES    = 64;
   // Spare cycles after the last result, so the execute stage is surely empty.
   localparam int unsigned DRAIN_CYCLES   = 6;
   localparam int unsigned MAX_REPORTS    = 10;
   localparam int unsigned MAX_GAP        = 20;
   localparam int unsigned RANDOM_PER_PHASE = 85;

   // All inputs of the unit start at known values.
   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata   = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_wr_en   = 1'b0;
   logic [PC_W-1:0]         csr_wr_data = '0;

   chip8_instruction_executor_unit #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Architectural state as the testbench believes it to be. It advances by
   // one instruction every time a word is accepted on the request side.
   // ------------------------------------------------------------------------
   logic [VREG_W-1:0] cpu_v   [NUM_V];
   logic [PC_W-1:0]   cpu_pc;
   int unsigned       cpu_sp;
   logic [PC_W-1:0]   cpu_stack [STACK_DEPTH];

   // Results still owed by the unit, oldest first.
   rsp_fields_type    owed_results[$];
   int unsigned       mismatch_count = 0;

   // Traffic shaping knobs, in percent per cycle.
   int unsigned       send_idle_pct = 0;
   int unsigned       stall_pct     = 0;
   // Long receiver hold-off: requested by the stimulus, timed by the receiver.
   bit                hold_request  = 1'b0;
   bit                hold_done     = 1'b0;
   int unsigned       hold_count    = 0;
   int unsigned       quiet_cycles  = 0;

   // The legal 8XYn functions, used to build well-formed ALU words.
   alu_type           legal_alu [9] = '{ALU_LD, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD,
                                        ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL};

   // ------------------------------------------------------------------------
   // Directed table. A row either carries its result typed in (fields from
   // illegal_op down to next_pc, the order of rsp_fields_type) or leaves the
   // result to the instruction model below.
   // ------------------------------------------------------------------------
   typedef struct packed {
      logic [INSTR_W-1:0] word;
      logic               typed;
      rsp_fields_type     result;
   } directed_row_type;

   localparam rsp_fields_type FROM_MODEL = '0;

   directed_row_type directed_rows [0:27] = '{
      // Zero word is an unhandled system call: only the PC moves.
      {16'h0000, 1'b1, {1'b1, 8'h00, 8'h00, 4'h0, 1'b0, 1'b0, 12'h202}},
      {INSTR_CLS, 1'b1, {1'b0, 8'h00, 8'h00, 4'h0, 1'b0, 1'b1, 12'h204}},
      {16'h6AFF, 1'b1, {1'b0, 8'h00, 8'hFF, 4'hA, 1'b1, 1'b0, 12'h206}},
      // Loading VF directly also shows up as the flag value.
      {16'h6F80, 1'b1, {1'b0, 8'h80, 8'h80, 4'hF, 1'b1, 1'b0, 12'h208}},
      // ADD immediate wraps 0xFF + 1 to zero and leaves VF alone.
      {16'h7A01, 1'b1, {1'b0, 8'h80, 8'h00, 4'hA, 1'b1, 1'b0, 12'h20A}},
      {16'h6B81, 1'b0, FROM_MODEL},
      // 0x81 + 0x80 carries out.
      {16'h8BF4, 1'b0, FROM_MODEL},
      {16'h8BA5, 1'b0, FROM_MODEL},
      {16'h8BA7, 1'b0, FROM_MODEL},
      {16'h8B06, 1'b0, FROM_MODEL},
      {16'h8B0E, 1'b0, FROM_MODEL},
      {16'h8BF1, 1'b0, FROM_MODEL},
      {16'h8BF2, 1'b0, FROM_MODEL},
      {16'h8BF3, 1'b0, FROM_MODEL},
      {16'h8AB0, 1'b0, FROM_MODEL},
      // ALU write to VF itself: the sum must win over the carry.
      {16'h8FB4, 1'b0, FROM_MODEL},
      {16'h3A00, 1'b0, FROM_MODEL},
      {16'h4AFF, 1'b0, FROM_MODEL},
      {16'h5AB0, 1'b0, FROM_MODEL},
      {16'h9AB0, 1'b0, FROM_MODEL},
      // Register compares with a nonzero low nibble and the unused ALU codes.
      {16'h5AB1, 1'b0, FROM_MODEL},
      {16'h9ABF, 1'b0, FROM_MODEL},
      {16'h8AB8, 1'b0, FROM_MODEL},
      {16'h8ABF, 1'b0, FROM_MODEL},
      {16'h2FFE, 1'b0, FROM_MODEL},
      {INSTR_RET, 1'b0, FROM_MODEL},
      // Jump to the top of the address space, then let the PC wrap to zero.
      {16'h1FFE, 1'b0, FROM_MODEL},
      {16'hFFFF, 1'b0, FROM_MODEL}
   };

   task automatic clear_cpu_state();
      for (int i = 0; i < NUM_V; i++) cpu_v[i] = '0;
      for (int i = 0; i < STACK_DEPTH; i++) cpu_stack[i] = '0;
      cpu_pc = PROGRAM_START_RESET;
      cpu_sp = 0;
   endtask

   // Executes one instruction on the testbench's copy of the CPU state and
   // returns the result word the unit should produce for it.
   function automatic rsp_fields_type execute_instruction(input logic [INSTR_W-1:0] w);
      logic [VIDX_W-1:0] x;
      logic [VIDX_W-1:0] y;
      logic [VREG_W-1:0] vx;
      logic [VREG_W-1:0] vy;
      logic [VREG_W-1:0] wval;
      logic [VREG_W-1:0] fval;
      logic [VREG_W:0]   sum;
      logic [PC_W-1:0]   npc;
      logic              cls;
      logic              wr;
      logic              fwr;
      logic              ill;
      rsp_fields_type    r;
      x    = w[11:8];
      y    = w[7:4];
      vx   = cpu_v[x];
      vy   = cpu_v[y];
      npc  = cpu_pc + PC_STEP;
      cls  = 1'b0;
      wr   = 1'b0;
      fwr  = 1'b0;
      ill  = 1'b0;
      wval = '0;
      fval = '0;
      sum  = {1'b0, vx} + {1'b0, vy};
      case (w[15:12])
         OP_SYS: begin
            if (w == INSTR_CLS) begin
               cls = 1'b1;
            end else if (w == INSTR_RET) begin
               cpu_sp = (cpu_sp + STACK_DEPTH - 1) % STACK_DEPTH;
               npc    = cpu_stack[cpu_sp];
            end else begin
               ill = 1'b1;
            end
         end
         OP_JP: npc = w[11:0];
         OP_CALL: begin
            cpu_stack[cpu_sp] = npc;
            cpu_sp            = (cpu_sp + 1) % STACK_DEPTH;
            npc               = w[11:0];
         end
         OP_SE_IMM:  if (vx == w[7:0]) npc = npc + PC_STEP;
         OP_SNE_IMM: if (vx != w[7:0]) npc = npc + PC_STEP;
         OP_SE_REG: begin
            if (w[3:0] != 4'h0) ill = 1'b1;
            else if (vx == vy) npc = npc + PC_STEP;
         end
         OP_SNE_REG: begin
            if (w[3:0] != 4'h0) ill = 1'b1;
            else if (vx != vy) npc = npc + PC_STEP;
         end
         OP_LD_IMM: begin
            wr   = 1'b1;
            wval = w[7:0];
         end
         OP_ADD_IMM: begin
            wr   = 1'b1;
            wval = vx + w[7:0];
         end
         OP_ALU: begin
            wr = 1'b1;
            case (w[3:0])
               ALU_LD:  wval = vy;
               ALU_OR:  wval = vx | vy;
               ALU_AND: wval = vx & vy;
               ALU_XOR: wval = vx ^ vy;
               ALU_ADD: begin
                  fwr  = 1'b1;
                  fval = {7'd0, sum[VREG_W]};
                  wval = sum[VREG_W-1:0];
               end
               ALU_SUB: begin
                  fwr  = 1'b1;
                  fval = {7'd0, vx > vy};
                  wval = vx - vy;
               end
               ALU_SHR: begin
                  fwr  = 1'b1;
                  fval = {7'd0, vx[0]};
                  wval = vx >> 1;
               end
               ALU_SUBN: begin
                  fwr  = 1'b1;
                  fval = {7'd0, vy > vx};
                  wval = vy - vx;
               end
               ALU_SHL: begin
                  fwr  = 1'b1;
                  fval = {7'd0, vx[7]};
                  wval = vx << 1;
               end
               default: begin
                  wr  = 1'b0;
                  ill = 1'b1;
               end
            endcase
         end
         default: ill = 1'b1;
      endcase
      // The flag goes first so that an ALU result aimed at VF overwrites it.
      if (fwr) cpu_v[VF_INDEX] = fval;
      if (wr) cpu_v[x] = wval;
      cpu_pc = npc;
      r.next_pc         = npc;
      r.clear_display   = cls;
      r.reg_write_valid = wr;
      r.reg_write_index = wr ? x : '0;
      r.reg_write_value = wr ? wval : '0;
      r.flag_value      = cpu_v[VF_INDEX];
      r.illegal_op      = ill;
      return r;
   endfunction

   // Mostly well-formed instructions with random operands; skips are steered
   // toward taken and not-taken about equally, a share is pure noise.
   function automatic logic [INSTR_W-1:0] random_instruction();
      logic [3:0]        x;
      logic [3:0]        y;
      logic [3:0]        n;
      logic [VREG_W-1:0] kk;
      x  = 4'($urandom_range(15));
      y  = 4'($urandom_range(15));
      n  = 4'($urandom_range(15));
      kk = $urandom_range(1) ? cpu_v[x] : 8'($urandom_range(255));
      if ($urandom_range(3) == 0) y = x;
      case ($urandom_range(15))
         0:  return 16'($urandom_range(65535));
         1:  return INSTR_CLS;
         2:  return INSTR_RET;
         3:  return {OP_CALL, x, y, n};
         4:  return {OP_JP, x, y, n};
         5:  return {OP_SE_IMM, x, kk};
         6:  return {OP_SNE_IMM, x, kk};
         7:  return {OP_SE_REG, x, y, 4'h0};
         8:  return {OP_SNE_REG, x, y, 4'h0};
         9:  return {OP_LD_IMM, x, kk};
         10: return {OP_ADD_IMM, x, kk};
         15: begin
            case ($urandom_range(3))
               0: return {4'($urandom_range(15, 10)), x, y, n};
               1: return {($urandom_range(1) ? OP_SE_REG : OP_SNE_REG), x, y,
                          4'($urandom_range(15, 1))};
               2: return {OP_ALU, x, y,
                          ($urandom_range(1) ? 4'hF : 4'($urandom_range(13, 8)))};
               default: return {OP_SYS, 12'($urandom_range(4095))};
            endcase
         end
         default: return {OP_ALU, x, y, legal_alu[$urandom_range(8)]};
      endcase
   endfunction

   // Offers one instruction word, waits for the handshake and books the result
   // it must produce. Valid stays high between back-to-back words.
   task automatic send_instruction(input logic [INSTR_W-1:0] w, input logic typed,
                                   input rsp_fields_type typed_result);
      int unsigned    gap;
      rsp_fields_type predicted;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = execute_instruction(w);
      owed_results.push_back(typed ? typed_result : predicted);
   endtask

   task automatic send_random_instructions(input int unsigned count);
      for (int i = 0; i < count; i++) send_instruction(random_instruction(), 1'b0, FROM_MODEL);
   endtask

   // Stops offering words and lets every owed result come back, plus a few
   // cycles so the execute stage is surely empty.
   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // The program start register also loads the PC; registers and stack stay.
   task automatic write_program_start(input logic [PC_W-1:0] addr);
      wait_until_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= addr;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cpu_pc = addr;
   endtask

   task automatic report_failure(input string what, input rsp_fields_type want,
                                 input rsp_fields_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t %s: want pc=%h cls=%b wr=%b idx=%h val=%h vf=%h ill=%b, ",
                  $realtime, what, want.next_pc, want.clear_display, want.reg_write_valid,
                  want.reg_write_index, want.reg_write_value, want.flag_value,
                  want.illegal_op,
                  "got pc=%h cls=%b wr=%b idx=%h val=%h vf=%h ill=%b",
                  got.next_pc, got.clear_display, got.reg_write_valid,
                  got.reg_write_index, got.reg_write_value, got.flag_value,
                  got.illegal_op);
   endtask

   // ------------------------------------------------------------------------
   // Result side: the receiver either follows the stall rate or, once asked,
   // holds tready low for a long stretch so the unit backs up into req_tready.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_request && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_count <= hold_count + 1;
         if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Every accepted result word is matched against the oldest owed result.
   always @(posedge clock) begin : check_result
      rsp_fields_type got;
      rsp_fields_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_fields_type'(rsp_tdata[RSP_FIELDS_W-1:0]);
         if (owed_results.size() == 0) begin
            report_failure("unexpected result", FROM_MODEL, got);
         end else begin
            want = owed_results.pop_front();
            if (got.next_pc !== want.next_pc
                || got.clear_display !== want.clear_display
                || got.reg_write_valid !== want.reg_write_valid
                || got.reg_write_index !== want.reg_write_index
                || got.reg_write_value !== want.reg_write_value
                || got.flag_value !== want.flag_value
                || got.illegal_op !== want.illegal_op)
               report_failure("result mismatch", want, got);
         end
      end
   end

   // Hang detection: counts cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("** chip8_instruction_executor_unit: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus: directed table first at the reset program start, then random
   // phases, each behind a new program start and a different traffic shape.
   // ------------------------------------------------------------------------
   initial begin
      clear_cpu_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(directed_rows); i++)
         send_instruction(directed_rows[i].word, directed_rows[i].typed,
                          directed_rows[i].result);

      // Highest address: the first fetch step wraps the PC to 0x001.
      write_program_start(12'hFFF);
      send_random_instructions(RANDOM_PER_PHASE);

      send_idle_pct = 55;
      write_program_start(12'h000);
      send_random_instructions(RANDOM_PER_PHASE);

      send_idle_pct = 0;
      stall_pct     = 55;
      write_program_start(12'($urandom_range(4095)));
      send_random_instructions(RANDOM_PER_PHASE);

      send_idle_pct = 23;
      stall_pct     = 23;
      write_program_start(12'hFFE);
      send_random_instructions(RANDOM_PER_PHASE);

      // Back-pressure: the receiver goes quiet while the sender keeps offering.
      send_idle_pct = 0;
      stall_pct     = 0;
      write_program_start(PROGRAM_START_RESET);
      hold_request = 1'b1;
      send_random_instructions(RANDOM_PER_PHASE);

      wait_until_idle();
      if (mismatch_count == 0 && owed_results.size() == 0)
         $display("** chip8_instruction_executor_unit: PASSED **");
      else
         $display("** chip8_instruction_executor_unit: FAILED **");
      $finish;
   end

endmodule
